FILE: hw/rtl/epd_pkg.sv
// shared types, constants and decode helpers for the packet decoder
// and resistance measurement block; no dependencies
package epd_pkg;

  typedef logic signed [21:0] sample_t;

  localparam logic [1:0] MODE_STOP   = 2'd0;
  localparam logic [1:0] MODE_SIGNAL = 2'd1;
  localparam logic [1:0] MODE_RESIST = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;
  localparam logic [1:0] REG_GAIN  = 2'd2;

  localparam logic KIND_PAIR   = 1'b0;
  localparam logic KIND_RESIST = 1'b1;

  // deviation accumulator is split in two 24-bit chunks for the gain product
  localparam int DW = 48;
  localparam int PW = 72;
  localparam int NW = PW - 16;

  typedef struct packed {
    logic        done;
    logic        ovr;
    logic [31:0] ohms;
  } mad_res_t;

  // left-justified signed word divided by 2048, truncated toward zero
  function automatic sample_t base_div(input logic [31:0] u);
    logic signed [20:0] q;
    begin
      q = 21'($signed(u) >>> 11);
      if (u[31] && (u[10:0] != 11'd0)) q = q + 21'sd1;
      return {q[20], q};
    end
  endfunction

  function automatic logic [1:0] chan_order(input logic [1:0] k);
    logic [1:0] c;
    begin
      unique case (k)
        2'd0: c = 2'd1;
        2'd1: c = 2'd2;
        2'd2: c = 2'd0;
        default: c = 2'd3;
      endcase
      return c;
    end
  endfunction

endpackage

FILE: hw/rtl/epd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module epd_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 101
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/epd_decode.sv
// unpacks packet number, button flag and eight samples from a 20-byte packet
// depends on epd_pkg
module epd_decode import epd_pkg::*; (
  input  logic [63:0]       bytes_first,
  input  logic [63:0]       bytes_middle,
  input  logic [31:0]       bytes_tail,
  output logic [10:0]       pkt,
  output logic              btn,
  output sample_t [7:0]     smp
);

  logic [7:0] b [20];
  logic [31:0] u [4];
  logic signed [15:0] dl [4];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i]     = bytes_first[63-8*i -: 8];
      b[8 + i] = bytes_middle[63-8*i -: 8];
    end
    for (int i = 0; i < 4; i++) b[16 + i] = bytes_tail[31-8*i -: 8];

    pkt = {b[0], b[1][7:5]};
    btn = b[1][4];

    u[0] = {b[1][3:0], b[2], b[3], b[4], 4'b0};
    u[1] = {b[4][6:0], b[5], b[6], b[7], 1'b0};
    u[2] = {b[6][1:0], b[7], b[8], b[9], 6'b0};
    u[3] = {b[9][4:0], b[10], b[11], 11'b0};

    for (int i = 0; i < 4; i++) begin
      dl[i]      = $signed({b[12 + 2*i], b[13 + 2*i]});
      smp[i]     = base_div(u[i]);
      smp[4 + i] = smp[i] + {{6{dl[i][15]}}, dl[i]};
    end
  end

endmodule

FILE: hw/rtl/epd_mad.sv
// resistance sequencer: scans kept samples through one shared multiplier,
// then scales by the gain and divides bit-serially; depends on epd_pkg
module epd_mad import epd_pkg::*; #(
  parameter int WINDOW = 100
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [$clog2(WINDOW+2)-1:0]    n,
  input  logic signed [21+$clog2(WINDOW+2):0] sum,
  input  logic [20:0]                    thr,
  input  logic [23:0]                    gain,
  output logic                           rd_en,
  output logic [$clog2(WINDOW+1)-1:0]    rd_addr,
  input  sample_t                        rd_data,
  output mad_res_t                       res
);

  localparam int CW = $clog2(WINDOW + 2);
  localparam int AW = $clog2(WINDOW + 1);
  localparam int SW = 22 + CW;
  localparam int TW = SW + 1;
  localparam int QW = 2 * CW;
  localparam int KW = $clog2(NW + 1);

  typedef enum logic [3:0] {
    M_IDLE, M_RD, M_MUL, M_ACC, M_GLO, M_GHI, M_NSQ, M_DINIT, M_DIV, M_DONE
  } mstate_t;

  mstate_t state;
  logic [CW-1:0] n_q;
  logic [CW-1:0] j;
  logic [DW-1:0] d_acc;
  logic [PW-1:0] p_acc;
  logic [NW-1:0] numq;
  logic [QW-1:0] divisor;
  logic [QW-1:0] rem;
  logic [KW-1:0] step;
  logic          ovr;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] mul_p, mul_q;
  logic signed [TW-1:0] t;
  logic [TW-1:0] t_abs;
  logic [QW:0]   rem_sh;
  logic          q_bit;

  assign rd_en   = (state == M_RD);
  assign rd_addr = j[AW-1:0];

  // the one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      M_MUL: begin
        mul_a = $signed({{(25-CW){1'b0}}, n_q});
        mul_b = $signed({{3{rd_data[21]}}, rd_data});
      end
      M_GLO: begin
        mul_a = $signed({1'b0, d_acc[23:0]});
        mul_b = $signed({1'b0, gain});
      end
      M_GHI: begin
        mul_a = $signed({1'b0, d_acc[47:24]});
        mul_b = $signed({1'b0, gain});
      end
      M_NSQ: begin
        mul_a = $signed({{(25-CW){1'b0}}, n_q});
        mul_b = $signed({{(25-CW){1'b0}}, n_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    t      = $signed(mul_q[TW-1:0]) - $signed({sum[SW-1], sum});
    t_abs  = t[TW-1] ? TW'(-t) : TW'(t);
    rem_sh = {rem, numq[NW-1]};
    q_bit  = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    mul_q <= mul_p;
    if (rst) begin
      state    <= M_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            n_q   <= n;
            j     <= '0;
            d_acc <= '0;
            ovr   <= 1'b0;
            state <= (n == '0) ? M_DONE : M_RD;
            numq  <= '0;
          end
        end
        M_RD:  state <= M_MUL;
        M_MUL: begin
          if (rd_data >= $signed({1'b0, thr})) ovr <= 1'b1;
          state <= M_ACC;
        end
        M_ACC: begin
          d_acc <= d_acc + {{(DW-TW){1'b0}}, t_abs};
          j     <= j + 1'b1;
          state <= (j + 1'b1 == n_q) ? M_GLO : M_RD;
        end
        M_GLO: state <= M_GHI;
        M_GHI: begin
          p_acc <= {{(PW-48){1'b0}}, mul_q[47:0]};
          state <= M_NSQ;
        end
        M_NSQ: begin
          p_acc <= p_acc + {mul_q[47:0], 24'b0};
          state <= M_DINIT;
        end
        M_DINIT: begin
          numq    <= p_acc[PW-1:16];
          divisor <= mul_q[QW-1:0];
          rem     <= '0;
          step    <= '0;
          state   <= M_DIV;
        end
        M_DIV: begin
          rem  <= q_bit ? QW'(rem_sh - {1'b0, divisor}) : rem_sh[QW-1:0];
          numq <= {numq[NW-2:0], q_bit};
          step <= step + 1'b1;
          if (step == KW'(NW - 1)) state <= M_DONE;
        end
        M_DONE: begin
          res.done <= 1'b1;
          res.ovr  <= ovr;
          if (ovr || (|numq[NW-1:32])) res.ohms <= 32'hFFFF_FFFF;
          else res.ohms <= numq[31:0];
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/eeg_packet_decode_impedance_core.sv
// top level: packet decode, result sequencing, sample buffer and config
// depends on epd_pkg, epd_decode, epd_ram, epd_mad
// One packet is taken at a time. A packet in signal or resist mode gives four
// channel results (channels 1, 2, 0, 3), one per cycle when the output is
// free, and resist mode then writes the current channel's two samples into
// the buffer (states T_WRA, T_WRB) when both are nonzero. When the window
// fills, the resistance result follows the buffer scan and the divide: each
// kept sample takes one pass through the single shared multiplier and the
// final divide retires one quotient bit a cycle. Stopped mode takes a packet
// and gives nothing. The buffer needs no clearing after reset.
module eeg_packet_decode_impedance_core import epd_pkg::*; #(
  parameter int WINDOW = 100,
  parameter int SKIP   = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        bytes_first,
  input  logic [63:0]        bytes_middle,
  input  logic [31:0]        bytes_tail,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [1:0]         channel,
  output logic signed [21:0] sample_first,
  output logic signed [21:0] sample_second,
  output logic [10:0]        packet_number,
  output logic               button_changed,
  output logic [31:0]        resistance_ohms,
  output logic               overrange,
  output logic               last
);

  localparam int CW    = $clog2(WINDOW + 2);
  localparam int DEPTH = WINDOW + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = 22 + CW;

  typedef enum logic [2:0] {
    T_IDLE, T_PAIR, T_WRA, T_WRB, T_CALC, T_WAIT, T_RES
  } tstate_t;

  tstate_t state;
  logic [1:0]  mode;
  logic [20:0] thr;
  logic [23:0] gain;
  logic [1:0]  rchan;
  logic [CW-1:0] count;
  logic signed [SW-1:0] ksum;

  sample_t [7:0] s_q;
  logic [10:0] pkt_q;
  logic        btn_q;
  logic [1:0]  k;
  logic        resist_go, res_due;
  sample_t     wa, wb;

  logic [10:0]   d_pkt;
  logic          d_btn;
  sample_t [7:0] d_smp;
  sample_t       cur_a, cur_b, wsel;
  logic [1:0]    pc;

  logic          load_ok, accept, kept, out_load;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  sample_t       rd_data;
  logic [CW-1:0] n_kept;
  mad_res_t      mres;

  epd_decode u_dec (
    .bytes_first (bytes_first),
    .bytes_middle(bytes_middle),
    .bytes_tail  (bytes_tail),
    .pkt         (d_pkt),
    .btn         (d_btn),
    .smp         (d_smp)
  );

  epd_ram #(.WIDTH(22), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wsel),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  epd_mad #(.WINDOW(WINDOW)) u_mad (
    .clk    (clk),
    .rst    (rst),
    .start  (state == T_CALC),
    .n      (n_kept),
    .sum    (ksum),
    .thr    (thr),
    .gain   (gain),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .res    (mres)
  );

  assign in_stall = (state != T_IDLE);
  assign accept   = in_valid && (state == T_IDLE);
  assign load_ok  = !out_valid || !out_stall;

  always_comb begin
    cur_a     = d_smp[rchan];
    cur_b     = d_smp[{1'b1, rchan}];
    pc        = chan_order(k);
    wsel      = (state == T_WRB) ? wb : wa;
    kept      = (32'(count) >= 32'(SKIP));
    ram_we    = ((state == T_WRA) || (state == T_WRB)) && kept;
    ram_waddr = AW'(32'(count) - 32'(SKIP));
    n_kept    = (32'(count) > 32'(SKIP)) ? CW'(32'(count) - 32'(SKIP)) : '0;
    out_load  = ((state == T_PAIR) || (state == T_RES)) && load_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
      mode      <= MODE_STOP;
      thr       <= 21'd1048575;
      gain      <= 24'd520835;
      rchan     <= '0;
      count     <= '0;
      ksum      <= '0;
    end else begin
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE: begin
            if (cfg_data[1:0] != mode) begin
              rchan <= '0;
              count <= '0;
              ksum  <= '0;
            end
            mode <= cfg_data[1:0];
          end
          REG_THR:  thr  <= cfg_data[20:0];
          REG_GAIN: gain <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        T_IDLE: begin
          if (accept && (mode == MODE_SIGNAL || mode == MODE_RESIST)) begin
            s_q       <= d_smp;
            pkt_q     <= d_pkt;
            btn_q     <= d_btn;
            wa        <= cur_a;
            wb        <= cur_b;
            k         <= '0;
            resist_go <= (mode == MODE_RESIST) && (cur_a != '0) && (cur_b != '0);
            res_due   <= (mode == MODE_RESIST) && (cur_a != '0) && (cur_b != '0)
                         && (32'(count) + 32'd2 >= 32'(WINDOW));
            state     <= T_PAIR;
          end
        end
        T_PAIR: begin
          if (load_ok) begin
            out_valid       <= 1'b1;
            kind            <= KIND_PAIR;
            channel         <= pc;
            sample_first    <= (mode == MODE_SIGNAL) ? s_q[pc] : '0;
            sample_second   <= (mode == MODE_SIGNAL) ? s_q[{1'b1, pc}] : '0;
            packet_number   <= pkt_q;
            button_changed  <= btn_q;
            resistance_ohms <= '0;
            overrange       <= 1'b0;
            last            <= (k == 2'd3) && !res_due;
            k               <= k + 1'b1;
            if (k == 2'd3) state <= resist_go ? T_WRA : T_IDLE;
          end
        end
        T_WRA, T_WRB: begin
          if (kept) ksum <= ksum + {{(SW-22){wsel[21]}}, wsel};
          count <= count + 1'b1;
          if (state == T_WRA) state <= T_WRB;
          else state <= res_due ? T_CALC : T_IDLE;
        end
        T_CALC: state <= T_WAIT;
        T_WAIT: if (mres.done) state <= T_RES;
        T_RES: begin
          if (load_ok) begin
            out_valid       <= 1'b1;
            kind            <= KIND_RESIST;
            channel         <= rchan;
            sample_first    <= '0;
            sample_second   <= '0;
            packet_number   <= pkt_q;
            button_changed  <= btn_q;
            resistance_ohms <= mres.ohms;
            overrange       <= mres.ovr;
            last            <= 1'b1;
            count           <= '0;
            ksum            <= '0;
            rchan           <= rchan + 1'b1;
            state           <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/epd_checker.sv
// port-level checks for the packet decoder, bound to the top level
// depends on eeg_packet_decode_impedance_core
module epd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        kind,
  input logic [1:0]  channel,
  input logic [31:0] resistance_ohms,
  input logic        overrange,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(channel)
      && $stable(resistance_ohms))
    else $error("stalled item changed");

  a_res_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> last)
    else $error("resistance item not last");

  a_pair_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> (resistance_ohms == 32'd0) && !overrange)
    else $error("pair item carries resistance");

  a_ovr_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && overrange |-> (resistance_ohms == 32'hFFFF_FFFF))
    else $error("overrange without saturated ohms");

endmodule

bind eeg_packet_decode_impedance_core epd_checker u_epd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .channel        (channel),
  .resistance_ohms(resistance_ohms),
  .overrange      (overrange),
  .last           (last)
);
